[sv/icrr_pkg.sv]
// ----------------------------------------------------------------------------
// icrr_pkg: shared definitions for the round-robin instruction cache
// Geometry defaults, request and response codes, and the command and status
// records between the controller and the datapath.
// ----------------------------------------------------------------------------
package icrr_pkg;

   // default geometry: 4 ways, 128 sets, 4 words per line
   localparam int DEF_WAY_BITS  = 2;
   localparam int DEF_SET_BITS  = 7;
   localparam int DEF_WORD_BITS = 2;

   localparam int ADDR_W = 32;
   localparam int DATA_W = 32;

   // request codes
   localparam logic [1:0] FUNC_FETCH = 2'd0;
   localparam logic [1:0] FUNC_INVAL = 2'd1;
   localparam logic [1:0] FUNC_FILL  = 2'd2;

   // response codes
   localparam logic [1:0] KIND_WORD   = 2'd0;
   localparam logic [1:0] KIND_REFILL = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       lookup;       // capture request, read tag and valid rows
      logic       clear_row;    // reset sweep: zero one valid row
      logic       miss;         // start refill, drop victim line
      logic       inval;        // drop matching lines
      logic       fill_write;   // store one refill word
      logic       fill_finish;  // write tag, mark line valid, read result word
      logic       hit_read;     // read word of the hitting way
      logic       set_result;   // latch response kind and hit flag
      logic [1:0] kind;
      logic       result_hit;
      logic       out_load;     // move response into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] func;
      logic       pending;
      logic       hit;
      logic       fill_last;
      logic       clear_done;
      logic       out_free;
   } status_type;

endpackage

[sv/icrr_chan_if.sv]
// ----------------------------------------------------------------------------
// icrr channel interfaces
// Request and response channels with valid/ready flow control.
// ----------------------------------------------------------------------------
interface icrr_req_if import icrr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] fill_word;

   modport source (output valid, func, address, fill_word, input ready);
   modport sink   (input valid, func, address, fill_word, output ready);
endinterface

interface icrr_rsp_if import icrr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [DATA_W-1:0] data;
   logic [ADDR_W-1:0] refill_address;
   logic              was_hit;

   modport source (output valid, kind, data, refill_address, was_hit, input ready);
   modport sink   (input valid, kind, data, refill_address, was_hit, output ready);
endinterface

[sv/set_assoc_icache_round_robin_core.sv]
// A request transfer reads its tag and valid rows; the lookup state compares and
// updates; the response state loads the output register, waiting while it is full
// until the response transfer. Requests are taken only in the idle state, so each
// waits for the last to finish. An invalidate or a non-final refill word
// gets no response. Reset: synchronous; the valid rows are then swept clear, one
// set per cycle, with req ready held low.
// ----------------------------------------------------------------------------
// set_assoc_icache_round_robin_core: set-associative instruction cache
// Round-robin victim choice, line refill by fill-word requests, invalidate.
// ----------------------------------------------------------------------------
module set_assoc_icache_round_robin_core import icrr_pkg::*; #(
   parameter int WAY_BITS  = DEF_WAY_BITS,
   parameter int SET_BITS  = DEF_SET_BITS,
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   icrr_req_if.sink   req_bus,
   icrr_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type sts;

   // sequencing
   icrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and response path
   icrr_dpath #(
      .WAY_BITS  (WAY_BITS),
      .SET_BITS  (SET_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_bus.func),
      .req_address        (req_bus.address),
      .req_fill_word      (req_bus.fill_word),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_kind           (rsp_bus.kind),
      .rsp_data           (rsp_bus.data),
      .rsp_refill_address (rsp_bus.refill_address),
      .rsp_was_hit        (rsp_bus.was_hit)
   );

endmodule

[sv/icrr_ctrl.sv]
// ----------------------------------------------------------------------------
// icrr_ctrl: cache controller
// Sequences the reset sweep, request lookup, state update and response.
// ----------------------------------------------------------------------------
module icrr_ctrl import icrr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_LOOK  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_row = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.lookup = 1'b1;
               state_in   = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.set_result = 1'b1;
            cmd.kind       = KIND_ERROR;
            state_in       = ST_RESP;
            unique case (sts.func)
               FUNC_FETCH: begin
                  if (sts.pending) begin
                     cmd.kind = KIND_ERROR;
                  end else if (sts.hit) begin
                     cmd.hit_read   = 1'b1;
                     cmd.kind       = KIND_WORD;
                     cmd.result_hit = 1'b1;
                  end else begin
                     cmd.miss = 1'b1;
                     cmd.kind = KIND_REFILL;
                  end
               end
               FUNC_INVAL: begin
                  // no response
                  cmd.inval      = 1'b1;
                  cmd.set_result = 1'b0;
                  state_in       = ST_IDLE;
               end
               FUNC_FILL: begin
                  if (sts.pending) begin
                     cmd.fill_write = 1'b1;
                     if (sts.fill_last) begin
                        cmd.fill_finish = 1'b1;
                        cmd.kind        = KIND_WORD;
                     end else begin
                        cmd.set_result = 1'b0;
                        state_in       = ST_IDLE;
                     end
                  end
               end
               default: begin
                  cmd.kind = KIND_ERROR;
               end
            endcase
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

[sv/icrr_dpath.sv]
// ----------------------------------------------------------------------------
// icrr_dpath: cache datapath
// Tag, valid and data memories, refill bookkeeping, victim pointer and the
// response output register.
// ----------------------------------------------------------------------------
module icrr_dpath import icrr_pkg::*; #(
   parameter int WAY_BITS  = DEF_WAY_BITS,
   parameter int SET_BITS  = DEF_SET_BITS,
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        sts,
   input  logic [1:0]        req_func,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_fill_word,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [1:0]        rsp_kind,
   output logic [DATA_W-1:0] rsp_data,
   output logic [ADDR_W-1:0] rsp_refill_address,
   output logic              rsp_was_hit
);

   localparam int NWAYS       = 1 << WAY_BITS;
   localparam int NSETS       = 1 << SET_BITS;
   localparam int NWORDS      = 1 << WORD_BITS;
   localparam int WAY_W       = (WAY_BITS > 0) ? WAY_BITS : 1;
   localparam int WORD_W      = (WORD_BITS > 0) ? WORD_BITS : 1;
   localparam int OFFSET_BITS = WORD_BITS + 2;
   localparam int TAG_SHIFT   = SET_BITS + OFFSET_BITS;
   localparam int TAG_W       = ADDR_W - TAG_SHIFT;
   localparam int IDX_W       = WAY_BITS + SET_BITS + WORD_BITS;
   localparam int NDATA       = 1 << IDX_W;

   localparam logic [WAY_W-1:0]  WAY_MASK  = WAY_W'(NWAYS - 1);
   localparam logic [WORD_W-1:0] WORD_MASK = WORD_W'(NWORDS - 1);
   localparam logic [ADDR_W-1:0] LINE_MASK = ADDR_W'((1 << OFFSET_BITS) - 1);
   localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(NSETS - 1);

   function automatic logic [SET_BITS-1:0] set_of(input logic [ADDR_W-1:0] a);
      return SET_BITS'(a >> OFFSET_BITS);
   endfunction

   function automatic logic [WORD_W-1:0] word_of(input logic [ADDR_W-1:0] a);
      return WORD_W'(a >> 2) & WORD_MASK;
   endfunction

   function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a);
      return TAG_W'(a >> TAG_SHIFT);
   endfunction

   function automatic logic [IDX_W-1:0] data_idx(input logic [WAY_W-1:0]    way,
                                                 input logic [SET_BITS-1:0] set_idx,
                                                 input logic [WORD_W-1:0]   word);
      return (IDX_W'(way) << (SET_BITS + WORD_BITS)) |
             (IDX_W'(set_idx) << WORD_BITS) | IDX_W'(word);
   endfunction

   // captured request
   logic [1:0]          func_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [DATA_W-1:0]   fword_ff;
   logic [SET_BITS-1:0] look_set_ff;

   // refill bookkeeping
   logic                pending_ff;
   logic [ADDR_W-1:0]   pend_addr_ff;
   logic [WAY_W-1:0]    pend_way_ff;
   logic [WORD_W-1:0]   fill_cnt_ff;
   logic [WAY_W-1:0]    victim_ff;
   logic [SET_BITS-1:0] sweep_ff;

   // response staging
   logic [1:0]          kind_ff;
   logic                hitflag_ff;
   logic                bypass_ff;
   logic [DATA_W-1:0]   rdata_ff;
   logic                out_valid_ff;
   logic [1:0]          out_kind_ff;
   logic [DATA_W-1:0]   out_data_ff;
   logic [ADDR_W-1:0]   out_raddr_ff;
   logic                out_hit_ff;

   logic [SET_BITS-1:0] item_set, pend_set, lookup_set, valid_wa;
   logic [TAG_W-1:0]    item_tag;
   logic [WORD_W-1:0]   item_word, pend_word;
   logic [NWAYS-1:0]    valid_rd_ff, valid_wd, match, victim_mask, pend_mask;
   logic                valid_we;
   logic [WAY_W-1:0]    hit_way;
   logic [TAG_W-1:0]    tag_rd [NWAYS];
   logic                data_re;
   logic [IDX_W-1:0]    data_ra, data_wa;

   assign item_set   = set_of(addr_ff);
   assign item_tag   = tag_of(addr_ff);
   assign item_word  = word_of(addr_ff);
   assign pend_set   = set_of(pend_addr_ff);
   assign pend_word  = word_of(pend_addr_ff);
   assign lookup_set = (req_func == FUNC_FILL) ? pend_set : set_of(req_address);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         func_ff     <= req_func;
         addr_ff     <= req_address;
         fword_ff    <= req_fill_word;
         look_set_ff <= lookup_set;
      end
   end

   // per-way tag memories
   for (genvar g = 0; g < NWAYS; g++) begin : g_way
      logic [TAG_W-1:0] tag_mem [NSETS];
      logic [TAG_W-1:0] tag_rd_ff;

      always_ff @(posedge clock) begin
         if (cmd.fill_finish && (pend_way_ff == WAY_W'(g))) begin
            tag_mem[pend_set] <= tag_of(pend_addr_ff);
         end
         if (cmd.lookup) begin
            tag_rd_ff <= tag_mem[lookup_set];
         end
      end

      assign tag_rd[g] = tag_rd_ff;
   end

   // tag compare across ways, lowest matching way wins
   always_comb begin
      hit_way = '0;
      for (int w = 0; w < NWAYS; w++) begin
         match[w] = valid_rd_ff[w] && (tag_rd[w] == item_tag);
      end
      for (int w = NWAYS - 1; w >= 0; w--) begin
         if (match[w]) hit_way = WAY_W'(w);
      end
   end

   assign victim_mask = NWAYS'(1) << victim_ff;
   assign pend_mask   = NWAYS'(1) << pend_way_ff;

   // valid memory, one row of way bits per set
   logic [NWAYS-1:0] valid_mem [NSETS];

   assign valid_we = cmd.clear_row | cmd.miss | cmd.inval | cmd.fill_finish;
   assign valid_wa = cmd.clear_row ? sweep_ff : look_set_ff;

   always_comb begin
      priority if (cmd.clear_row) begin
         valid_wd = '0;
      end else if (cmd.miss) begin
         valid_wd = valid_rd_ff & ~victim_mask;
      end else if (cmd.inval) begin
         valid_wd = valid_rd_ff & ~match;
      end else begin
         valid_wd = valid_rd_ff | pend_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[valid_wa] <= valid_wd;
      end
      if (cmd.lookup) begin
         valid_rd_ff <= valid_mem[lookup_set];
      end
   end

   // data memory indexed by {way, set, word}
   logic [DATA_W-1:0] data_mem [NDATA];

   assign data_re = cmd.hit_read | cmd.fill_finish;
   assign data_wa = data_idx(pend_way_ff, pend_set, fill_cnt_ff);
   assign data_ra = cmd.hit_read ? data_idx(hit_way, item_set, item_word)
                                 : data_idx(pend_way_ff, pend_set, pend_word);

   always_ff @(posedge clock) begin
      if (cmd.fill_write) begin
         data_mem[data_wa] <= fword_ff;
      end
      if (data_re) begin
         rdata_ff  <= data_mem[data_ra];
         // requested word is the one written in this cycle
         bypass_ff <= cmd.fill_finish && (pend_word == fill_cnt_ff);
      end
   end

   // refill bookkeeping and reset sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         pend_addr_ff <= '0;
         pend_way_ff  <= '0;
         fill_cnt_ff  <= '0;
         victim_ff    <= '0;
         sweep_ff     <= '0;
      end else begin
         if (cmd.clear_row) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
         if (cmd.miss) begin
            pending_ff   <= 1'b1;
            pend_addr_ff <= addr_ff;
            pend_way_ff  <= victim_ff;
            fill_cnt_ff  <= '0;
            victim_ff    <= (victim_ff + 1'b1) & WAY_MASK;
         end
         if (cmd.fill_write) begin
            fill_cnt_ff <= (fill_cnt_ff + 1'b1) & WORD_MASK;
         end
         if (cmd.fill_finish) begin
            pending_ff <= 1'b0;
         end
      end
   end

   // response kind and hit flag
   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         kind_ff    <= cmd.kind;
         hitflag_ff <= cmd.result_hit;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_kind_ff  <= kind_ff;
         out_hit_ff   <= hitflag_ff;
         out_data_ff  <= (kind_ff != KIND_WORD) ? '0 : (bypass_ff ? fword_ff : rdata_ff);
         out_raddr_ff <= (kind_ff == KIND_REFILL) ? (pend_addr_ff & ~LINE_MASK) : '0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_data           = out_data_ff;
   assign rsp_refill_address = out_raddr_ff;
   assign rsp_was_hit        = out_hit_ff;

   // status
   assign sts.func       = func_ff;
   assign sts.pending    = pending_ff;
   assign sts.hit        = |match;
   assign sts.fill_last  = (fill_cnt_ff == WORD_MASK);
   assign sts.clear_done = (sweep_ff == LAST_SET);
   assign sts.out_free   = !out_valid_ff || rsp_ready;

endmodule

[sv/icrr_checker.sv]
// ----------------------------------------------------------------------------
// icrr_checker: port-level checks for the instruction cache
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module icrr_checker import icrr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_kind,
   input logic [DATA_W-1:0] rsp_data,
   input logic [ADDR_W-1:0] rsp_refill_address,
   input logic              rsp_was_hit
);

   // sweep follows reset: nothing taken, nothing offered
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ready && !rsp_valid)
      else $error("request taken or response offered right after reset");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in the cycle after a request transfer");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data)
         && $stable(rsp_refill_address) && $stable(rsp_was_hit))
      else $error("stalled response changed");

   // only word responses carry data or a hit flag
   a_word_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_WORD) |-> (rsp_data == '0) && !rsp_was_hit)
      else $error("data or hit flag on a non-word response");

   // only refill responses carry an address
   a_refill_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_REFILL) |-> (rsp_refill_address == '0))
      else $error("refill address on a non-refill response");

endmodule

bind set_assoc_icache_round_robin_core icrr_checker u_icrr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_kind           (rsp_bus.kind),
   .rsp_data           (rsp_bus.data),
   .rsp_refill_address (rsp_bus.refill_address),
   .rsp_was_hit        (rsp_bus.was_hit)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the round-robin instruction cache
// Directed fetch, refill, invalidate and protocol-error sequences, then random
// refill sequences over a small pool of conflicting lines. A behavioral cache
// model predicts each response, and the monitor checks it in order. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import icrr_pkg::*;

   // geometry
   localparam int WAY_BITS  = DEF_WAY_BITS;
   localparam int SET_BITS  = DEF_SET_BITS;
   localparam int WORD_BITS = DEF_WORD_BITS;
   localparam int WAYS      = 1 << WAY_BITS;
   localparam int SETS      = 1 << SET_BITS;
   localparam int WORDS     = 1 << WORD_BITS;
   localparam int LINE_W    = WAY_BITS + SET_BITS;
   localparam int OFS_W     = WORD_BITS + 2;
   localparam int TAG_LSB   = SET_BITS + OFS_W;
   localparam int TAG_W     = ADDR_W - TAG_LSB;
   localparam logic [ADDR_W-1:0] LINE_MASK = (ADDR_W'(1) << OFS_W) - 1;

   // selector value with no defined request
   localparam logic [1:0] FUNC_BAD = 2'd3;

   localparam int RANDOM_ITEMS = 650;
   localparam int IDLE_PCT     = 32;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [1:0]        kind;
      logic [DATA_W-1:0] data;
      logic [ADDR_W-1:0] refill_address;
      logic              was_hit;
   } cache_rsp_type;

   typedef struct {
      logic [1:0]        func;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] fill_word;
      bit                has_rsp;
      cache_rsp_type     rsp;
   } cache_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   icrr_req_if req_bus ();
   icrr_rsp_if rsp_bus ();

   set_assoc_icache_round_robin_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cache model state
   logic [TAG_W-1:0]     tag_mem   [WAYS*SETS];
   bit                   valid_mem [WAYS*SETS];
   logic [DATA_W-1:0]    word_mem  [WAYS*SETS*WORDS];
   logic [WAY_BITS-1:0]  victim_ptr = '0;
   logic [WAY_BITS-1:0]  fill_way   = '0;
   bit                   refilling  = 1'b0;
   logic [ADDR_W-1:0]    miss_addr  = '0;
   logic [WORD_BITS-1:0] fill_idx   = '0;

   cache_req_type fetch_stream_q[$];
   cache_rsp_type owed_rsp_q[$];
   cache_req_type on_bus;
   cache_rsp_type seen_rsp, want_rsp;
   int            total_items = 0;
   int            accepted    = 0;
   int            errors      = 0;

   // address pools so that lines conflict and get evicted
   logic [TAG_W-1:0]    tag_pool [6];
   logic [SET_BITS-1:0] set_pool [4];

   // no idling on either side for a stretch in the middle of the run
   wire steady = (accepted >= 200) && (accepted < 330);

   // Behavioral cache: applies one request, returns 1 when it gives a response
   function automatic bit cache_respond(input logic [1:0] func,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [DATA_W-1:0] fw,
                                        output cache_rsp_type rsp);
      logic [SET_BITS-1:0]  set_idx;
      logic [TAG_W-1:0]     tag;
      logic [WORD_BITS-1:0] word_sel;
      logic [LINE_W-1:0]    line;
      int                   w;
      rsp      = '0;
      set_idx  = addr[OFS_W +: SET_BITS];
      word_sel = addr[2 +: WORD_BITS];
      tag      = addr[ADDR_W-1:TAG_LSB];
      case (func)
         FUNC_FETCH: begin
            if (refilling) begin
               rsp.kind = KIND_ERROR;
               return 1'b1;
            end
            for (w = 0; w < WAYS; w++) begin
               line = LINE_W'((w << SET_BITS) | set_idx);
               if (valid_mem[line] && tag_mem[line] == tag) begin
                  rsp.kind    = KIND_WORD;
                  rsp.data    = word_mem[{line, word_sel}];
                  rsp.was_hit = 1'b1;
                  return 1'b1;
               end
            end
            // miss: take the round-robin victim and drop it right away
            fill_way   = victim_ptr;
            victim_ptr = victim_ptr + 1'b1;
            valid_mem[{fill_way, set_idx}] = 1'b0;
            refilling  = 1'b1;
            miss_addr  = addr;
            fill_idx   = '0;
            rsp.kind   = KIND_REFILL;
            rsp.refill_address = addr & ~LINE_MASK;
            return 1'b1;
         end
         FUNC_INVAL: begin
            for (w = 0; w < WAYS; w++) begin
               line = LINE_W'((w << SET_BITS) | set_idx);
               if (valid_mem[line] && tag_mem[line] == tag)
                  valid_mem[line] = 1'b0;
            end
            return 1'b0;
         end
         FUNC_FILL: begin
            if (!refilling) begin
               rsp.kind = KIND_ERROR;
               return 1'b1;
            end
            line = {fill_way, miss_addr[OFS_W +: SET_BITS]};
            word_mem[{line, fill_idx}] = fw;
            if (fill_idx == WORD_BITS'(WORDS - 1)) begin
               // last word: line goes valid, requested word comes back
               fill_idx        = '0;
               tag_mem[line]   = miss_addr[ADDR_W-1:TAG_LSB];
               valid_mem[line] = 1'b1;
               refilling       = 1'b0;
               rsp.kind        = KIND_WORD;
               rsp.data        = word_mem[{line, miss_addr[2 +: WORD_BITS]}];
               return 1'b1;
            end
            fill_idx = fill_idx + 1'b1;
            return 1'b0;
         end
         default: begin
            rsp.kind = KIND_ERROR;
            return 1'b1;
         end
      endcase
   endfunction

   // Predict the request's response and queue it for the driver
   task automatic queue_req(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] fw);
      cache_req_type item;
      item.func      = func;
      item.address   = addr;
      item.fill_word = fw;
      item.has_rsp   = cache_respond(func, addr, fw, item.rsp);
      fetch_stream_q.push_back(item);
      total_items++;
   endtask

   // Mostly pooled addresses, some fully random
   function automatic logic [ADDR_W-1:0] pick_addr();
      if ($urandom_range(99) < 15)
         return $urandom;
      return {tag_pool[$urandom_range(5)], set_pool[$urandom_range(3)],
              OFS_W'($urandom)};
   endfunction

   task automatic report(input string what, input cache_rsp_type want,
                         input cache_rsp_type seen);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("%s: expected kind %0d data %h refill %h hit %b,",
                  what, want.kind, want.data, want.refill_address, want.was_hit);
         $display("   got kind %0d data %h refill %h hit %b",
                  seen.kind, seen.data, seen.refill_address, seen.was_hit);
      end
   endtask

   // Driver: one request per transfer, random idle cycles
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (on_bus.has_rsp)
               owed_rsp_q.push_back(on_bus.rsp);
            accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (fetch_stream_q.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PCT)) begin
               on_bus = fetch_stream_q.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.func      <= on_bus.func;
               req_bus.address   <= on_bus.address;
               req_bus.fill_word <= on_bus.fill_word;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response transfer against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp = {rsp_bus.kind, rsp_bus.data, rsp_bus.refill_address,
                        rsp_bus.was_hit};
            if (owed_rsp_q.size() == 0) begin
               report("unexpected response", '0, seen_rsp);
            end else begin
               want_rsp = owed_rsp_q.pop_front();
               if (seen_rsp.kind !== want_rsp.kind || seen_rsp.data !== want_rsp.data ||
                   seen_rsp.refill_address !== want_rsp.refill_address ||
                   seen_rsp.was_hit !== want_rsp.was_hit)
                  report("response mismatch", want_rsp, seen_rsp);
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Stimulus and end of run
   initial begin
      int n;
      int roll;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_FETCH;
      req_bus.address   = '0;
      req_bus.fill_word = '0;
      rsp_bus.ready     = 1'b0;

      foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
      foreach (set_pool[i]) set_pool[i] = SET_BITS'($urandom);
      tag_pool[0] = '0;
      tag_pool[1] = '1;

      // miss on address zero, refill with extreme words, then a hit
      queue_req(FUNC_FETCH, 32'h0000_0000, '0);
      queue_req(FUNC_FILL, $urandom, 32'hFFFF_FFFF);
      queue_req(FUNC_FILL, $urandom, 32'h0000_0000);
      queue_req(FUNC_FILL, $urandom, 32'hA5A5_5A5A);
      queue_req(FUNC_FILL, $urandom, 32'h1234_5678);
      queue_req(FUNC_FETCH, 32'h0000_0004, '0);
      // top address; fetch, invalidate of the same line and bad selector mid-refill
      queue_req(FUNC_FETCH, 32'hFFFF_FFFF, '0);
      queue_req(FUNC_FETCH, 32'h0000_0000, '0);
      queue_req(FUNC_INVAL, 32'hFFFF_FFFF, '0);
      queue_req(FUNC_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(FUNC_FILL, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
      queue_req(FUNC_FILL, 32'h0000_0000, 32'hF0F0_F0F0);
      queue_req(FUNC_FILL, $urandom, 32'h0000_0001);
      queue_req(FUNC_FILL, $urandom, 32'h8000_0000);
      queue_req(FUNC_FETCH, 32'hFFFF_FFFC, '0);
      // fill with nothing pending, invalidate, then the line misses again
      queue_req(FUNC_FILL, $urandom, 32'hDEAD_BEEF);
      queue_req(FUNC_INVAL, 32'h0000_0000, '0);
      queue_req(FUNC_FETCH, 32'h0000_0008, '0);
      for (n = 0; n < WORDS; n++)
         queue_req(FUNC_FILL, $urandom, $urandom);
      queue_req(FUNC_BAD, 32'h0000_0000, 32'h0000_0000);

      // random part: mostly well-formed refill sequences, some noise
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(99);
         if (refilling) begin
            if (roll < 88)
               queue_req(FUNC_FILL, $urandom, $urandom);
            else if (roll < 93)
               queue_req(FUNC_FETCH, pick_addr(), $urandom);
            else if (roll < 97)
               queue_req(FUNC_INVAL, (roll & 1) ? miss_addr : pick_addr(), $urandom);
            else
               queue_req(FUNC_BAD, $urandom, $urandom);
         end else begin
            if (roll < 72)
               queue_req(FUNC_FETCH, pick_addr(), $urandom);
            else if (roll < 84)
               queue_req(FUNC_INVAL, pick_addr(), $urandom);
            else if (roll < 91)
               queue_req(FUNC_FILL, $urandom, $urandom);
            else if (roll < 95)
               queue_req(FUNC_BAD, $urandom, $urandom);
            else
               queue_req(FUNC_FETCH, $urandom, $urandom);
         end
      end
      // finish any open refill
      while (refilling)
         queue_req(FUNC_FILL, $urandom, $urandom);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // all requests sent and every response back
      do
         @(negedge clock);
      while (accepted != total_items || owed_rsp_q.size() != 0);
      // catch stray responses
      repeat (24) @(posedge clock);

      if (errors == 0 && owed_rsp_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end

endmodule
